>>> src/bounded_array_list_top_assert.svh
// assertion macros for the bounded array list rtl
// depends on nothing; included by bounded_array_list_top to check its own logic
`ifndef BOUNDED_ARRAY_LIST_TOP_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_TOP_ASSERT_SVH

// expression holds at every edge out of reset
`define BAL_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BAL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define BAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bal_pkg.sv
// shared types, codes and sizes for the bounded array list
// depends on nothing
package bal_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 4;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CMP_W    = (CNT_W > INDEX_W + 1) ? CNT_W : INDEX_W + 1;

    localparam logic [OP_W-1:0] OP_PUSH_BACK = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT_AT = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE_AT = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_AT   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [INDEX_W-1:0]        index;
        logic signed [WORD_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [WORD_W-1:0]  value_out;
        logic [COUNT_W-1:0]        count;
    } out_item_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_mode_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        cell_mode_t         mode;
        logic [ADDR_W-1:0]  pos;
        logic [WORD_W-1:0]  value;
    } cell_cmd_t;

endpackage

>>> src/bounded_array_list_top.sv
// top level of the bounded array list: request decode, fill count, result register
// depends on bal_pkg, bal_chain, bounded_array_list_top_assert.svh
//
//  channel   direction  handshake             payload
//  request   in         in_valid / in_ready   in_item  (op, index, value)
//  result    out        out_valid / out_ready out_item (status, value_out, count)
//
// a transfer is decoded and the affected cells of the row shift in the same cycle
// the result is loaded into the output register at the request transfer edge
// a new request is taken while the result register is empty or being drained
// reset clears the fill count and the result valid; stored words are unknown until written
// a stalled result holds and blocks only further requests
`include "bounded_array_list_top_assert.svh"

module bounded_array_list_top
    import bal_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
);

    // fill count and result register
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    out_item_t           out_item_reg;

    // decode results
    logic                in_xfer;
    logic [STATUS_W-1:0] status;
    cell_mode_t          mode;
    logic [ADDR_W-1:0]   pos;
    logic [ADDR_W-1:0]   rd_addr;
    logic                take_word;
    logic                full;
    logic                empty;
    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    cnt_ext;
    cell_cmd_t           cmd;
    logic [WORD_W-1:0]   rd_word;

    // terms for the checks at the end
    logic                fail_xfer;
    logic                push_ok;
    logic                bad_res;
    logic [CNT_W-1:0]    cnt_inc;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    assign full    = (count_reg >= CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign idx_ext = CMP_W'(in_item.index);
    assign cnt_ext = CMP_W'(count_reg);

    // request decode; the full check comes ahead of the index check
    always_comb
    begin
        status     = ST_OK;
        mode       = CELL_HOLD;
        pos        = ADDR_W'(in_item.index);
        rd_addr    = ADDR_W'(in_item.index);
        take_word  = 1'b0;
        count_next = count_reg;
        case (in_item.op)
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    // append is an insert at the current count
                    mode       = CELL_INSERT;
                    pos        = ADDR_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    mode       = CELL_REMOVE;
                    pos        = '0;
                    rd_addr    = '0;
                    take_word  = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    // nothing moves, the last word simply drops out of range
                    rd_addr    = ADDR_W'(count_reg - 1'b1);
                    take_word  = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_INSERT_AT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else if (idx_ext > cnt_ext)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    mode       = CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE_AT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (idx_ext >= cnt_ext)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    mode       = CELL_REMOVE;
                    take_word  = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_READ_AT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (idx_ext >= cnt_ext)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    take_word = 1'b1;
                end
            end
            default:
            begin
                // unused op codes
                status = ST_RANGE;
            end
        endcase
    end

    // cells only move on an accepted request
    always_comb
    begin
        cmd.mode  = in_xfer ? mode : CELL_HOLD;
        cmd.pos   = pos;
        cmd.value = in_item.value;
    end

    bal_chain u_chain (
        .clk     (clk),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .rd_word (rd_word)
    );

    // control state: fill count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each request transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_item_reg.status    <= status;
            out_item_reg.value_out <= take_word ? rd_word : '0;
            out_item_reg.count     <= COUNT_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign fail_xfer = in_xfer && (status != ST_OK);
    assign push_ok   = in_xfer && (status == ST_OK) && (in_item.op == OP_PUSH_BACK);
    assign bad_res   = out_valid_reg && (out_item_reg.status != ST_OK);
    assign cnt_inc   = count_reg + 1'b1;

    // checks on the decode and count logic
    `BAL_ASSERT_ALWAYS(a_count_max, clk, rst_n, count_reg <= CNT_W'(CAPACITY), "count too big")
    `BAL_ASSERT_NEXT(a_fail_hold, clk, rst_n, fail_xfer, $stable(count_reg), "fail moved count")
    `BAL_ASSERT_NEXT(a_push_inc, clk, rst_n, push_ok, count_reg == $past(cnt_inc), "push kept count")
    `BAL_ASSERT_SAME(a_fail_zero, clk, rst_n, bad_res, out_item.value_out == '0, "word on failure")

endmodule

>>> src/bal_cell.sv
// one storage cell of the list row: holds, loads, or takes a neighbor word
// depends on bal_pkg
module bal_cell
    import bal_pkg::*;
(
    input  logic                clk,
    input  logic [ADDR_W-1:0]   cell_pos,
    input  cell_cmd_t           cmd,
    input  logic [WORD_W-1:0]   left_word,
    input  logic [WORD_W-1:0]   right_word,
    output logic [WORD_W-1:0]   word
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        case (cmd.mode)
            CELL_INSERT:
            begin
                if (cell_pos == cmd.pos)
                begin
                    word_next = cmd.value;
                end
                else if (cell_pos > cmd.pos)
                begin
                    word_next = left_word;
                end
            end
            CELL_REMOVE:
            begin
                if (cell_pos >= cmd.pos)
                begin
                    word_next = right_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

>>> src/bal_chain.sv
// row of list cells wired to their neighbors, with the single read select
// depends on bal_pkg and bal_cell
module bal_chain
    import bal_pkg::*;
(
    input  logic                clk,
    input  cell_cmd_t           cmd,
    input  logic [ADDR_W-1:0]   rd_addr,
    output logic [WORD_W-1:0]   rd_word
);

    logic [WORD_W-1:0] words [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        // cell 0 never takes its left input; last cell's right is itself
        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = words[i];
        end
        else
        begin : g_right
            assign right_w = words[i+1];
        end

        bal_cell u_cell (
            .clk        (clk),
            .cell_pos   (ADDR_W'(i)),
            .cmd        (cmd),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[i])
        );
    end

    assign rd_word = words[rd_addr];

endmodule

>>> verif/bal_list_checker.sv
`timescale 1ns / 1ps
// checker for the bounded array list: keeps a shadow copy of the list and compares replies
// depends on bal_pkg; sits beside the block in tb and only watches its channels
module bal_list_checker
    import bal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_item,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_item,
    output int          outstanding,
    output int          errors
);

    logic signed [WORD_W-1:0] list_words [CAPACITY];
    int                       list_len;
    out_item_t                list_replies [$];

    // applies one request to the shadow list and returns the reply it should give
    function automatic out_item_t apply_list_op(input in_item_t req);
        out_item_t rsp;
        int        i;
        int        pos;
        rsp.status    = ST_OK;
        rsp.value_out = '0;
        pos           = int'(req.index);
        case (req.op)
            OP_PUSH_BACK:
                if (list_len >= CAPACITY) rsp.status = ST_FULL;
                else
                begin
                    list_words[list_len] = req.value;
                    list_len++;
                end
            OP_POP_FRONT:
                if (list_len == 0) rsp.status = ST_EMPTY;
                else
                begin
                    rsp.value_out = list_words[0];
                    for (i = 0; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
                    list_len--;
                end
            OP_POP_BACK:
                if (list_len == 0) rsp.status = ST_EMPTY;
                else
                begin
                    list_len--;
                    rsp.value_out = list_words[list_len];
                end
            OP_INSERT_AT:
                // full wins over a bad index
                if (list_len >= CAPACITY) rsp.status = ST_FULL;
                else if (pos > list_len) rsp.status = ST_RANGE;
                else
                begin
                    for (i = list_len; i > pos; i--) list_words[i] = list_words[i - 1];
                    list_words[pos] = req.value;
                    list_len++;
                end
            OP_REMOVE_AT:
                if (list_len == 0) rsp.status = ST_EMPTY;
                else if (pos >= list_len) rsp.status = ST_RANGE;
                else
                begin
                    rsp.value_out = list_words[pos];
                    for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
                    list_len--;
                end
            OP_READ_AT:
                if (list_len == 0) rsp.status = ST_EMPTY;
                else if (pos >= list_len) rsp.status = ST_RANGE;
                else rsp.value_out = list_words[pos];
            default:
                rsp.status = ST_RANGE;
        endcase
        rsp.count = COUNT_W'(list_len);
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            list_len = 0;
            errors   = 0;
            list_replies.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (list_replies.size() == 0)
                begin
                    $error("reply transfer with no request waiting: %0d %0d %0d",
                           out_item.status, out_item.value_out, out_item.count);
                    errors++;
                end
                else
                begin
                    want = list_replies.pop_front();
                    if (out_item.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_item.status);
                        errors++;
                    end
                    if (out_item.value_out !== want.value_out)
                    begin
                        $error("value_out: expected %0d, got %0d", want.value_out,
                               out_item.value_out);
                        errors++;
                    end
                    if (out_item.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, out_item.count);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready) list_replies.push_back(apply_list_op(in_item));
            outstanding <= list_replies.size();
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// testbench top for bounded_array_list_top: clock, reset, request stimulus, reply sink, verdict
// depends on bal_pkg, bal_list_checker and the block's rtl
module tb;
    import bal_pkg::*;

    // the two op codes the block does not define
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS   = 1420;
    localparam int CALM_ITEMS     = 150;   // tail of the run with no idling on either side
    localparam int SQUEEZE_AT     = 200;   // request count at which the sink holds off
    localparam int SQUEEZE_CYCLES = 120;
    localparam int DRAIN_CYCLES   = 6;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    int        outstanding;
    int        errors;
    int        sent      = 0;
    bit        calm      = 1'b0;   // set by the request side for the tail of the run
    bit        squeeze_req = 1'b0; // request side asks the sink for one long hold-off

    always #5 clk = ~clk;

    bounded_array_list_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    bal_list_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .outstanding (outstanding),
        .errors      (errors)
    );

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2ms;
        $display("bounded_array_list_top: mismatch");
        $finish;
    end

    function automatic in_item_t list_req(input logic [OP_W-1:0] op,
                                          input logic [INDEX_W-1:0] index,
                                          input logic signed [WORD_W-1:0] value);
        in_item_t req;
        req.op    = op;
        req.index = index;
        req.value = value;
        return req;
    endfunction

    // mostly random words, now and then the corners
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // small indexes most of the time so that a good share land inside the list
    function automatic logic [INDEX_W-1:0] pick_index();
        if ($urandom_range(0, 9) < 6) return INDEX_W'($urandom_range(0, 7));
        return INDEX_W'($urandom_range(0, 15));
    endfunction

    // holds valid high until the transfer; leaves it high for a back-to-back follow-up
    task automatic offer(input in_item_t req);
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    task automatic maybe_pause(input int odds);
        if (!calm && odds != 0 && $urandom_range(1, odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // reply sink: random ready bursts, one long hold-off on request, steady ready when calm
    initial
    begin : reply_sink
        bit squeezed;
        squeezed = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (squeeze_req && !squeezed)
            begin
                squeezed = 1'b1;
                out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int mood;
        int span;
        int odds;
        int roll;
        int n;
        logic [OP_W-1:0] op;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every empty-list case first
        offer(list_req(OP_POP_FRONT, 4'd0, '0));
        offer(list_req(OP_POP_BACK,  4'd0, '0));
        offer(list_req(OP_REMOVE_AT, 4'd0, '0));
        offer(list_req(OP_READ_AT,   4'd0, '0));
        // insert one past the end of an empty list
        offer(list_req(OP_INSERT_AT, 4'd1, 32'sd5));
        offer(list_req(OP_INSERT_AT, 4'd0, 32'sh8000_0000));
        offer(list_req(OP_PUSH_BACK, 4'd0, 32'sh7fff_ffff));
        // index out of range with entries present
        offer(list_req(OP_READ_AT,   4'd15, '0));
        offer(list_req(OP_REMOVE_AT, 4'd2, '0));
        // insert exactly at count appends
        offer(list_req(OP_INSERT_AT, 4'd2, -32'sd1));
        offer(list_req(OP_SPARE_LO,  4'd3, 32'sd77));
        offer(list_req(OP_SPARE_HI,  4'd15, '1));
        maybe_pause(2);
        // fill up: twelve pushes then an insert at the top slot
        for (n = 0; n < 12; n++) offer(list_req(OP_PUSH_BACK, 4'd0, pick_word()));
        offer(list_req(OP_INSERT_AT, 4'd15, 32'sh1234_5678));
        // full list rejects both kinds of growth
        offer(list_req(OP_PUSH_BACK, 4'd0, 32'sd9));
        offer(list_req(OP_INSERT_AT, 4'd0, 32'sd10));
        offer(list_req(OP_READ_AT,   4'd15, '0));

        // random phases: fill-heavy, drain-heavy or mixed, each with its own idle rate
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            mood = $urandom_range(0, 2);
            span = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0:       odds = 0;
                1:       odds = 3;
                default: odds = 8;
            endcase
            while (span > 0 && n < RANDOM_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3) op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
                else if (mood == 0)
                    op = (roll < 45) ? OP_PUSH_BACK : (roll < 75) ? OP_INSERT_AT :
                         (roll < 85) ? OP_READ_AT : (roll < 92) ? OP_POP_FRONT :
                         (roll < 96) ? OP_POP_BACK : OP_REMOVE_AT;
                else if (mood == 1)
                    op = (roll < 30) ? OP_POP_FRONT : (roll < 55) ? OP_POP_BACK :
                         (roll < 80) ? OP_REMOVE_AT : (roll < 88) ? OP_READ_AT :
                         (roll < 94) ? OP_PUSH_BACK : OP_INSERT_AT;
                else
                    op = OP_W'($urandom_range(0, 5));
                if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
                if (sent == SQUEEZE_AT) squeeze_req = 1'b1;
                offer(list_req(op, pick_index(), pick_word()));
                maybe_pause(odds);
                n++;
                span--;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("bounded_array_list_top: match");
        else
            $display("bounded_array_list_top: mismatch");
        $finish;
    end

endmodule

>>> bounded_array_list_top.f
+incdir+src
src/bal_pkg.sv
src/bal_cell.sv
src/bal_chain.sv
src/bounded_array_list_top.sv
verif/bal_list_checker.sv
verif/tb.sv
